@@ hdl/rmv_pkg.sv @@
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared widths, codes and types for the binned running mean/variance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rmv_pkg;

    localparam int COUNT_W  = 24;
    localparam int MEAN_W   = 32;
    localparam int SUM_W    = 64;
    localparam int FRAC_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 7;
    localparam int RAD_W    = SUM_W + FRAC_W;
    localparam int ROOT_W   = RAD_W / 2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 88;

    localparam int NUM_BINS_DEF    = 128;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [MEAN_W-1:0]  MEAN_MAX  = '1;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0]   dev_sum;
        logic [MEAN_W-1:0]  mean;
        logic [COUNT_W-1:0] count;
    } bin_entry_t;

    typedef struct packed {
        logic               sat;
        logic [MEAN_W-1:0]  std_dev;
        logic [MEAN_W-1:0]  mean;
        logic [COUNT_W-1:0] count;
    } result_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DECIDE,
        ST_ADD_DIV,
        ST_ADD_MUL,
        ST_QRY_DIV,
        ST_QRY_SQRT,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ hdl/rmv_divider.sv @@
// ----------------------------------------------------------------------------
// rmv_divider
// Restoring divider, one quotient bit per cycle; 32 or 64 dividend bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_divider (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic                         short_mode,
    input  wire logic [rmv_pkg::SUM_W-1:0]    dividend,
    input  wire logic [rmv_pkg::COUNT_W-1:0]  divisor,
    output logic                              done,
    output logic [rmv_pkg::SUM_W-1:0]         quotient
);
    import rmv_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic                 active_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SUM_W-1:0]     dq_reg;
    logic [COUNT_W-1:0]   dvs_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [COUNT_W-1:0]   rem_next;
    logic                 qbit;
    logic [COUNT_W:0]     trial;

    always_comb begin
        trial = {rem_reg, dq_reg[SUM_W-1]};
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = COUNT_W'(trial - {1'b0, dvs_reg});
            qbit     = 1'b1;
        end else begin
            rem_next = trial[COUNT_W-1:0];
            qbit     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                active_reg <= 1'b1;
                cnt_reg    <= short_mode ? CNT_W'(MEAN_W) : CNT_W'(SUM_W);
            end else if (active_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // quotient bits enter at the bottom as dividend bits leave the top
    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= short_mode ? {dividend[MEAN_W-1:0], {(SUM_W-MEAN_W){1'b0}}}
                                  : dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (active_reg) begin
            dq_reg  <= {dq_reg[SUM_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

`default_nettype wire

@@ hdl/rmv_multiplier.sv @@
// ----------------------------------------------------------------------------
// rmv_multiplier
// Shift-add multiplier, one multiplier bit per cycle, 32 x 32 to 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_multiplier (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [rmv_pkg::MEAN_W-1:0]   mcand,
    input  wire logic [rmv_pkg::MEAN_W-1:0]   mplier,
    output logic                              done,
    output logic [2*rmv_pkg::MEAN_W-1:0]      product
);
    import rmv_pkg::*;

    localparam int CNT_W = $clog2(MEAN_W + 1);

    logic               active_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [MEAN_W-1:0]  a_reg;
    logic [MEAN_W-1:0]  hi_reg;
    logic [MEAN_W-1:0]  lo_reg;
    logic [MEAN_W:0]    psum;

    assign psum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(MEAN_W+1){1'b0}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                active_reg <= 1'b1;
                cnt_reg    <= CNT_W'(MEAN_W);
            end else if (active_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= mcand;
            hi_reg <= '0;
            lo_reg <= mplier;
        end else if (active_reg) begin
            hi_reg <= psum[MEAN_W:1];
            lo_reg <= {psum[0], lo_reg[MEAN_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

@@ hdl/rmv_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmv_sqrt
// Digit-by-digit integer square root of value * 2^16, two radicand bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_sqrt (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [rmv_pkg::SUM_W-1:0]    value,
    output logic                              done,
    output logic [rmv_pkg::ROOT_W-1:0]        root
);
    import rmv_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 2;

    logic               active_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   rem_next;
    logic [ROOT_W-1:0]  root_next;
    logic [REM_W+1:0]   shifted;
    logic [REM_W+1:0]   trial;

    always_comb begin
        shifted = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        if (shifted >= trial) begin
            rem_next  = REM_W'(shifted - trial);
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = shifted[REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                active_reg <= 1'b1;
                cnt_reg    <= CNT_W'(ROOT_W);
            end else if (active_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= {value, {FRAC_W{1'b0}}};
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (active_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            root_reg <= root_next;
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

@@ hdl/binned_running_mean_variance_unit.sv @@
// ----------------------------------------------------------------------------
// binned_running_mean_variance_unit
// Table of running-statistics bins: add folds a sample into a bin,
// query returns count, mean and sample standard deviation.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                          tuser
//  s_axis    in   bin_index[6:0], sample_value[22:7], pad     op
//  m_axis    out  sample_count, mean_value, std_deviation     saturated
//
//  add: serial divider (32 steps) then serial multiplier (32 steps);
//  query: serial divider (64 steps) then square root (40 steps); add to
//  an empty or full bin, or query of under two samples, skips them. one
//  word is worked at a time. after reset the bin table is cleared, no
//  word taken; a new word is taken while a result still waits on m_axis.
// ----------------------------------------------------------------------------
`default_nettype none

module binned_running_mean_variance_unit #(
    parameter int NUM_BINS    = rmv_pkg::NUM_BINS_DEF,
    parameter int SAMPLE_BITS = rmv_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // bin_index, sample_value, zero pad
    input  wire logic [rmv_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // op
    input  wire logic [0:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // sample_count, mean_value, std_deviation
    output logic [rmv_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // saturated
    output logic [0:0]                             m_axis_tuser
);
    import rmv_pkg::*;

    localparam int IDX_W = $clog2(NUM_BINS);
    localparam int MOD_W = IDX_W + 1;

    bin_entry_t             mem [NUM_BINS];
    bin_entry_t             rd_reg;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       clr_reg;
    logic                   op_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [MEAN_W-1:0]      x_reg;
    logic                   ge_reg;
    logic [MEAN_W-1:0]      d1_reg;
    logic [MEAN_W-1:0]      nm_reg;
    bin_entry_t             wr_reg;
    result_t                res_reg;
    logic                   out_valid_reg;
    result_t                out_reg;

    logic [MOD_W-1:0]       mod_v;
    logic [IDX_W-1:0]       idx_in;
    logic [SAMPLE_W-1:0]    sample_in;
    logic                   accept;
    logic                   first_add;

    logic                   ge_c;
    logic [MEAN_W-1:0]      d1_c;
    logic [MEAN_W-1:0]      nm_c;
    logic [MEAN_W-1:0]      d2_c;
    logic [SUM_W:0]         sum_c;

    logic                   div_start, div_short, div_done;
    logic [SUM_W-1:0]       div_dividend, div_q;
    logic [COUNT_W-1:0]     div_divisor;
    logic                   mul_start, mul_done;
    logic [2*MEAN_W-1:0]    mul_p;
    logic                   sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]      sqrt_root;

    // bin index modulo bin count, one restoring step per index bit
    always_comb begin
        mod_v = '0;
        for (int i = INDEX_W - 1; i >= 0; i--) begin
            mod_v = {mod_v[IDX_W-1:0], s_axis_tdata[i]};
            if (mod_v >= MOD_W'(NUM_BINS)) begin
                mod_v = mod_v - MOD_W'(NUM_BINS);
            end
        end
        idx_in = mod_v[IDX_W-1:0];
    end

    always_comb begin
        for (int i = 0; i < SAMPLE_W; i++) begin
            sample_in[i] = s_axis_tdata[INDEX_W+i] & (i < SAMPLE_BITS);
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign first_add     = (op_reg == OP_ADD) && (rd_reg.count == '0);

    // datapath pieces
    always_comb begin
        ge_c  = x_reg >= rd_reg.mean;
        d1_c  = ge_c ? (x_reg - rd_reg.mean) : (rd_reg.mean - x_reg);
        nm_c  = ge_reg ? (rd_reg.mean + div_q[MEAN_W-1:0])
                       : (rd_reg.mean - div_q[MEAN_W-1:0]);
        d2_c  = ge_reg ? (x_reg - nm_c) : (nm_c - x_reg);
        sum_c = {1'b0, rd_reg.dev_sum}
              + {{(SUM_W+1-(2*MEAN_W-FRAC_W)){1'b0}}, mul_p[2*MEAN_W-1:FRAC_W]};
    end

    assign div_short    = (op_reg == OP_ADD);
    assign div_dividend = (op_reg == OP_ADD) ? {{(SUM_W-MEAN_W){1'b0}}, d1_c}
                                             : rd_reg.dev_sum;
    assign div_divisor  = (op_reg == OP_ADD) ? (rd_reg.count + 1'b1)
                                             : (rd_reg.count - 1'b1);

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == IDX_W'(NUM_BINS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (op_reg == OP_ADD) begin
                    if (rd_reg.count == COUNT_MAX) begin
                        state_next = ST_DONE;
                    end else if (rd_reg.count == '0) begin
                        state_next = ST_WRITE;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_ADD_DIV;
                    end
                end else begin
                    if (rd_reg.count < COUNT_W'(2)) begin
                        state_next = ST_DONE;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_QRY_DIV;
                    end
                end
            end
            ST_ADD_DIV: begin
                // multiplier takes the new delta straight from the quotient
                if (div_done) begin
                    mul_start  = 1'b1;
                    state_next = ST_ADD_MUL;
                end
            end
            ST_ADD_MUL: begin
                if (mul_done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_QRY_DIV: begin
                if (div_done) begin
                    sqrt_start = 1'b1;
                    state_next = ST_QRY_SQRT;
                end
            end
            ST_QRY_SQRT: begin
                if (sqrt_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_WRITE: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ST_DONE && (!out_valid_reg || m_axis_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // bin table
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            mem[clr_reg] <= '0;
        end else if (state_reg == ST_WRITE) begin
            mem[idx_reg] <= wr_reg;
        end
        rd_reg <= mem[idx_reg];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_axis_tuser[0];
            idx_reg <= idx_in;
            x_reg   <= {sample_in, {FRAC_W{1'b0}}};
        end
        case (state_reg)
            ST_DECIDE: begin
                ge_reg <= ge_c;
                d1_reg <= d1_c;
                res_reg.count   <= first_add ? COUNT_W'(1) : rd_reg.count;
                res_reg.mean    <= first_add ? x_reg : rd_reg.mean;
                res_reg.std_dev <= '0;
                res_reg.sat     <= (op_reg == OP_ADD) && (rd_reg.count == COUNT_MAX);
                if (first_add) begin
                    wr_reg.count   <= COUNT_W'(1);
                    wr_reg.mean    <= x_reg;
                    wr_reg.dev_sum <= '0;
                end
            end
            ST_ADD_DIV: begin
                if (div_done) begin
                    nm_reg <= nm_c;
                end
            end
            ST_ADD_MUL: begin
                if (mul_done) begin
                    wr_reg.count   <= rd_reg.count + 1'b1;
                    wr_reg.mean    <= nm_reg;
                    wr_reg.dev_sum <= sum_c[SUM_W] ? {SUM_W{1'b1}} : sum_c[SUM_W-1:0];
                    res_reg.count  <= rd_reg.count + 1'b1;
                    res_reg.mean   <= nm_reg;
                    res_reg.sat    <= sum_c[SUM_W];
                end
            end
            ST_QRY_SQRT: begin
                if (sqrt_done) begin
                    if (sqrt_root[ROOT_W-1:MEAN_W] != '0) begin
                        res_reg.std_dev <= MEAN_MAX;
                        res_reg.sat     <= 1'b1;
                    end else begin
                        res_reg.std_dev <= sqrt_root[MEAN_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
        if (state_reg == ST_DONE && (!out_valid_reg || m_axis_tready)) begin
            out_reg <= res_reg;
        end
    end

    rmv_divider u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .short_mode (div_short),
        .dividend   (div_dividend),
        .divisor    (div_divisor),
        .done       (div_done),
        .quotient   (div_q)
    );

    rmv_multiplier u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (d1_reg),
        .mplier  (d2_c),
        .done    (mul_done),
        .product (mul_p)
    );

    rmv_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .value   (div_q),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.std_dev, out_reg.mean, out_reg.count};
    assign m_axis_tuser  = out_reg.sat;

endmodule

`default_nettype wire
